// ===== hdl/psc_pkg.sv =====
// Shared constants, payload structs and state types for the pile counter.
`default_nettype none
package psc_pkg;

    localparam int MAX_PILES   = 1024;
    localparam int IDX_W       = $clog2(MAX_PILES);
    localparam int CNT_W       = $clog2(MAX_PILES + 1);
    localparam int AREA_W      = 32;
    localparam int DIM_W       = 16;
    localparam int KIND_W      = 2;
    localparam int TOTAL_W     = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [KIND_W-1:0] SHAPE_TRIANGLE  = 2'd0;
    localparam logic [KIND_W-1:0] SHAPE_RECTANGLE = 2'd1;
    localparam logic [KIND_W-1:0] SHAPE_SQUARE    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] shape_kind;
        logic [DIM_W-1:0]  first_dim;
        logic [DIM_W-1:0]  second_dim;
    } shape_in_t;

    typedef struct packed {
        logic [AREA_W-1:0]  card_area;
        logic [TOTAL_W-1:0] pile_total;
        logic [TOTAL_W-1:0] tail_total;
        logic               overflow;
    } card_out_t;

    typedef struct packed {
        logic              start;
        logic              ack;
        logic [AREA_W-1:0] area;
    } lane_ctrl_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [CNT_W-1:0] count;
    } lane_stat_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_SEARCH,
        LN_DONE
    } lane_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_WAIT
    } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/psc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read on the same edge
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/psc_queue.sv =====
// Short area queue between the front stage and the back sequencer.
`default_nettype none
module psc_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push_valid,
    output logic                           push_ready,
    input  wire logic [psc_pkg::AREA_W-1:0] push_area,
    output logic                           pop_valid,
    input  wire logic                      pop_ready,
    output logic      [psc_pkg::AREA_W-1:0] pop_area
);

    logic [psc_pkg::AREA_W-1:0] slot_reg [psc_pkg::QUEUE_DEPTH];
    logic [psc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [psc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [psc_pkg::QPTR_W:0]   fill_reg, fill_next;
    logic                       do_push, do_pop;

    assign push_ready = (fill_reg != (psc_pkg::QPTR_W + 1)'(psc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_area   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed area
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_area;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/psc_front.sv =====
// Front stage: accept shapes, pick multiplier operands and compute the area.
`default_nettype none
module psc_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire psc_pkg::shape_in_t        in_data,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output logic      [psc_pkg::AREA_W-1:0] push_area
);

    logic                      stg_valid_reg, stg_valid_next;
    logic [psc_pkg::DIM_W-1:0] op_a_reg, op_b_reg;
    logic                      halve_reg;
    logic [psc_pkg::AREA_W-1:0] product;
    logic                      in_take;

    assign in_ready = !stg_valid_reg || push_ready;
    assign in_take  = in_valid && in_ready;

    // Hold the stage until the queue takes the area
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (in_take)
        begin
            stg_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Capture operands; unused kind code squares like a square
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_a_reg  <= in_data.first_dim;
            op_b_reg  <= (in_data.shape_kind == psc_pkg::SHAPE_TRIANGLE ||
                          in_data.shape_kind == psc_pkg::SHAPE_RECTANGLE) ?
                         in_data.second_dim : in_data.first_dim;
            halve_reg <= (in_data.shape_kind == psc_pkg::SHAPE_TRIANGLE);
        end
    end

    // Multiply and halve triangles
    assign product    = psc_pkg::AREA_W'(op_a_reg) * psc_pkg::AREA_W'(op_b_reg);
    assign push_area  = halve_reg ? (product >> 1) : product;
    assign push_valid = stg_valid_reg;

endmodule
`default_nettype wire

// ===== hdl/psc_lane.sv =====
// One sorted area array: append or binary-search replace, one RAM read per step.
`default_nettype none
module psc_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                eq_appends,
    input  wire psc_pkg::lane_ctrl_t ctrl,
    output psc_pkg::lane_stat_t      stat
);

    psc_pkg::lane_state_t state_reg, state_next;

    logic [psc_pkg::AREA_W-1:0] area_reg, area_next;
    logic [psc_pkg::AREA_W-1:0] last_reg, last_next;
    logic [psc_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [psc_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [psc_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [psc_pkg::IDX_W-1:0]  mid_reg, mid_next;
    logic                       ovf_reg, ovf_next;

    logic                       ram_we;
    logic [psc_pkg::IDX_W-1:0]  ram_waddr;
    logic [psc_pkg::AREA_W-1:0] ram_wdata;
    logic [psc_pkg::IDX_W-1:0]  ram_raddr;
    logic [psc_pkg::AREA_W-1:0] ram_rdata;

    logic                       append_hit;
    logic                       lane_full;
    logic                       below;
    logic [psc_pkg::CNT_W-1:0]  lo_step, hi_step, mid_step;
    logic                       step_more;

    psc_ram #(
        .WIDTH(psc_pkg::AREA_W),
        .DEPTH(psc_pkg::MAX_PILES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Classify a new area against the last entry
    assign append_hit = (count_reg == '0) || (last_reg < ctrl.area) ||
                        (eq_appends && (last_reg == ctrl.area));
    assign lane_full  = (count_reg == psc_pkg::CNT_W'(psc_pkg::MAX_PILES));

    // One lower-bound step on the entry read last cycle
    assign below     = (ram_rdata < area_reg);
    assign lo_step   = below ? psc_pkg::CNT_W'(mid_reg) + psc_pkg::CNT_W'(1) : lo_reg;
    assign hi_step   = below ? hi_reg : psc_pkg::CNT_W'(mid_reg);
    assign step_more = (lo_step < hi_step);
    assign mid_step  = lo_step + ((hi_step - lo_step) >> 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psc_pkg::LN_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = append_hit ? psc_pkg::LN_DONE : psc_pkg::LN_SEARCH;
                end
            end
            psc_pkg::LN_SEARCH:
            begin
                if (!step_more)
                begin
                    state_next = psc_pkg::LN_DONE;
                end
            end
            psc_pkg::LN_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = psc_pkg::LN_IDLE;
                end
            end
            default:
            begin
                state_next = psc_pkg::LN_IDLE;
            end
        endcase
    end

    // Datapath and RAM controls
    always_comb
    begin
        area_next  = area_reg;
        last_next  = last_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        ovf_next   = ovf_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[psc_pkg::IDX_W-1:0];
        ram_wdata  = area_reg;
        ram_raddr  = mid_reg;
        unique case (state_reg)
            psc_pkg::LN_IDLE:
            begin
                if (ctrl.start)
                begin
                    area_next = ctrl.area;
                    ovf_next  = 1'b0;
                    if (append_hit)
                    begin
                        if (lane_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[psc_pkg::IDX_W-1:0];
                            ram_wdata  = ctrl.area;
                            count_next = count_reg + 1'b1;
                            last_next  = ctrl.area;
                        end
                    end
                    else
                    begin
                        lo_next   = '0;
                        hi_next   = count_reg;
                        mid_next  = psc_pkg::IDX_W'(count_reg >> 1);
                        ram_raddr = mid_next;
                    end
                end
            end
            psc_pkg::LN_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (step_more)
                begin
                    mid_next  = psc_pkg::IDX_W'(mid_step);
                    ram_raddr = mid_next;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = psc_pkg::IDX_W'(lo_step);
                    ram_wdata = area_reg;
                    if (lo_step == count_reg - 1'b1)
                    begin
                        last_next = area_reg;
                    end
                end
            end
            psc_pkg::LN_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::LN_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
        last_reg <= last_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        ovf_reg  <= ovf_next;
    end

    assign stat.done  = (state_reg == psc_pkg::LN_DONE);
    assign stat.ovf   = ovf_reg;
    assign stat.count = count_reg;

endmodule
`default_nettype wire

// ===== hdl/psc_back.sv =====
// Back sequencer: pop an area, run both lanes, register the result.
`default_nettype none
module psc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pop_valid,
    output logic                            pop_ready,
    input  wire logic [psc_pkg::AREA_W-1:0] pop_area,
    output psc_pkg::lane_ctrl_t             pile_ctrl,
    output psc_pkg::lane_ctrl_t             tail_ctrl,
    input  wire psc_pkg::lane_stat_t        pile_stat,
    input  wire psc_pkg::lane_stat_t        tail_stat,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output psc_pkg::card_out_t              out_data
);

    psc_pkg::back_state_t state_reg, state_next;

    logic                       out_valid_reg, out_valid_next;
    psc_pkg::card_out_t         out_data_reg, out_data_next;
    logic [psc_pkg::AREA_W-1:0] area_reg, area_next;
    logic                       start;
    logic                       finish;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psc_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = psc_pkg::BK_WAIT;
                end
            end
            psc_pkg::BK_WAIT:
            begin
                if (finish)
                begin
                    state_next = psc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = psc_pkg::BK_IDLE;
            end
        endcase
    end

    // Lane controls and output register loading
    always_comb
    begin
        start  = (state_reg == psc_pkg::BK_IDLE) && pop_valid;
        finish = (state_reg == psc_pkg::BK_WAIT) && pile_stat.done && tail_stat.done &&
                 (!out_valid_reg || out_ready);

        pop_ready       = (state_reg == psc_pkg::BK_IDLE);
        pile_ctrl.start = start;
        pile_ctrl.ack   = finish;
        pile_ctrl.area  = pop_area;
        tail_ctrl.start = start;
        tail_ctrl.ack   = finish;
        tail_ctrl.area  = pop_area;

        area_next      = start ? pop_area : area_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (finish)
        begin
            out_valid_next           = 1'b1;
            out_data_next.card_area  = area_reg;
            out_data_next.pile_total = psc_pkg::TOTAL_W'(pile_stat.count);
            out_data_next.tail_total = psc_pkg::TOTAL_W'(tail_stat.count);
            out_data_next.overflow   = pile_stat.ovf || tail_stat.ovf;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg     <= area_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== hdl/patience_sort_pile_counter_top.sv =====
// Top level of the patience-sort pile counter over shape areas.
//
// Input channel in_valid/in_ready/in_data carries one shape per transaction
// (kind, two 16-bit dimensions). Output channel out_valid/out_ready/out_data
// returns one transaction per shape: its area, the strict pile count, the
// non-decreasing tail count and an overflow flag.
// The front stage registers the multiplier operands and multiplies on the
// way into a four-entry queue, so it keeps taking shapes while the back end
// works. The back end runs two lanes in parallel, each with its own RAM.
// An area that extends a lane is appended with no search; otherwise the lane
// runs a binary search with one RAM read per step, ceil(log2(count + 1))
// steps, at most 11 with 1024 entries. The search loop of the slower lane
// sets how long an item holds the back end; with an empty queue, an accepted
// shape passes the front register, the queue and the lanes into out_data.
// Reset clears both counts; the arrays need no clearing pass since only
// entries below the count are ever read. A stalled receiver holds the result
// in the output register; one more item finishes its search and waits,
// and the queue fills before in_ready drops.
`default_nettype none
module patience_sort_pile_counter_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire psc_pkg::shape_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output psc_pkg::card_out_t      out_data
);

    logic                       push_valid, push_ready;
    logic [psc_pkg::AREA_W-1:0] push_area;
    logic                       pop_valid, pop_ready;
    logic [psc_pkg::AREA_W-1:0] pop_area;
    psc_pkg::lane_ctrl_t        pile_ctrl, tail_ctrl;
    psc_pkg::lane_stat_t        pile_stat, tail_stat;

    psc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_area (push_area)
    );

    psc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_area (push_area),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_area  (pop_area)
    );

    // Strict piles: equal area replaces
    psc_lane u_pile_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .eq_appends(1'b0),
        .ctrl      (pile_ctrl),
        .stat      (pile_stat)
    );

    // Tails: equal area to the last tail appends
    psc_lane u_tail_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .eq_appends(1'b1),
        .ctrl      (tail_ctrl),
        .stat      (tail_stat)
    );

    psc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_area (pop_area),
        .pile_ctrl(pile_ctrl),
        .tail_ctrl(tail_ctrl),
        .pile_stat(pile_stat),
        .tail_stat(tail_stat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // A non-decreasing run is never shorter than a strictly increasing one
    a_tail_ge_pile: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tail_total >= out_data.pile_total))
        else $error("tail count below pile count");

    // Overflow only when a lane is at capacity
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.overflow) |->
        ((pile_stat.count == psc_pkg::CNT_W'(psc_pkg::MAX_PILES)) ||
         (tail_stat.count == psc_pkg::CNT_W'(psc_pkg::MAX_PILES))))
        else $error("overflow without a full lane");

    // Lanes are started and finished together
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        pile_ctrl.ack |-> (pile_stat.done && tail_stat.done))
        else $error("lane acknowledged before both finished");

    // Counts never exceed capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (pile_stat.count <= psc_pkg::CNT_W'(psc_pkg::MAX_PILES)) &&
        (tail_stat.count <= psc_pkg::CNT_W'(psc_pkg::MAX_PILES)))
        else $error("lane count beyond capacity");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the patience-sort pile counter: shape stimulus, area/pile/tail checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [psc_pkg::KIND_W-1:0] SHAPE_UNUSED  = 2'd3;
    localparam logic [psc_pkg::AREA_W-1:0] MAX_AREA      = 32'hFFFE_0001;
    localparam logic [psc_pkg::AREA_W-1:0] HALF_MAX_AREA = 32'h7FFF_0000;
    localparam int PILE_LANE     = 0;
    localparam int TAIL_LANE     = 1;
    localparam int DIRECTED_ROWS = 19;
    localparam int RAMP_LEN      = 400;
    localparam int HOLD_AFTER    = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int SHOWN_FAULTS  = 10;

    typedef struct packed {
        psc_pkg::shape_in_t shape;
        logic               typed;
        psc_pkg::card_out_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    psc_pkg::shape_in_t in_data;
    logic               out_valid;
    logic               out_ready;
    psc_pkg::card_out_t out_data;

    // Predictor state: sorted pile tops and sorted tails, one lane each
    logic [psc_pkg::AREA_W-1:0] sorted_areas [2][psc_pkg::MAX_PILES];
    int                         lane_len [2] = '{0, 0};

    psc_pkg::card_out_t pending_cards [$];
    stim_row_t          directed_rows [DIRECTED_ROWS];
    int                 shapes_sent = 0;
    int                 cards_seen  = 0;
    int                 fault_count = 0;

    patience_sort_pile_counter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Traffic phase follows the number of shapes sent: none, sender, receiver, both
    function automatic int traffic_phase();
        return (shapes_sent / 100) % 4;
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // Place one area into a lane: append when it extends the lane, else replace
    // the first entry not below it. Return 1 when an append hit capacity.
    function automatic logic place_area(input int lane,
                                        input logic [psc_pkg::AREA_W-1:0] area,
                                        input bit strict);
        int n;
        int lo;
        int hi;
        int mid;
        bit grow;
        n = lane_len[lane];
        if (n == 0)
            grow = 1'b1;
        else if (strict)
            grow = sorted_areas[lane][n-1] < area;
        else
            grow = sorted_areas[lane][n-1] <= area;
        if (grow)
        begin
            if (n >= psc_pkg::MAX_PILES)
                return 1'b1;
            sorted_areas[lane][n] = area;
            lane_len[lane] = n + 1;
            return 1'b0;
        end
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (sorted_areas[lane][mid] < area)
                lo = mid + 1;
            else
                hi = mid;
        end
        sorted_areas[lane][lo] = area;
        return 1'b0;
    endfunction

    // Compute the area of one shape and advance both lanes
    task automatic predict_card(input psc_pkg::shape_in_t s, output psc_pkg::card_out_t c);
        logic [63:0] product;
        logic        pile_full;
        logic        tail_full;
        case (s.shape_kind)
            psc_pkg::SHAPE_TRIANGLE:
                product = (64'(s.first_dim) * 64'(s.second_dim)) >> 1;
            psc_pkg::SHAPE_RECTANGLE:
                product = 64'(s.first_dim) * 64'(s.second_dim);
            default:
                product = 64'(s.first_dim) * 64'(s.first_dim);
        endcase
        pile_full = place_area(PILE_LANE, product[psc_pkg::AREA_W-1:0], 1'b1);
        tail_full = place_area(TAIL_LANE, product[psc_pkg::AREA_W-1:0], 1'b0);
        c.card_area  = product[psc_pkg::AREA_W-1:0];
        c.pile_total = psc_pkg::TOTAL_W'(lane_len[PILE_LANE]);
        c.tail_total = psc_pkg::TOTAL_W'(lane_len[TAIL_LANE]);
        c.overflow   = pile_full | tail_full;
    endtask

    function automatic stim_row_t shape_row(input logic [psc_pkg::KIND_W-1:0] kind,
                                            input logic [psc_pkg::DIM_W-1:0] d1,
                                            input logic [psc_pkg::DIM_W-1:0] d2,
                                            input bit typed,
                                            input logic [psc_pkg::AREA_W-1:0] area,
                                            input int piles, input int tails,
                                            input bit ovf);
        stim_row_t r;
        r.shape.shape_kind  = kind;
        r.shape.first_dim   = d1;
        r.shape.second_dim  = d2;
        r.typed             = typed;
        r.want.card_area    = area;
        r.want.pile_total   = psc_pkg::TOTAL_W'(piles);
        r.want.tail_total   = psc_pkg::TOTAL_W'(tails);
        r.want.overflow     = ovf;
        return r;
    endfunction

    function automatic logic [psc_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return psc_pkg::DIM_W'($urandom_range(15));
            4, 5:    return psc_pkg::DIM_W'($urandom_range(255));
            default: return psc_pkg::DIM_W'($urandom_range(65535));
        endcase
    endfunction

    // Offer one shape, hold it until accepted, then queue its expected card
    task automatic send_shape(input psc_pkg::shape_in_t s, input bit typed,
                              input psc_pkg::card_out_t typed_card);
        psc_pkg::card_out_t predicted;
        int                 idle_pct;
        case (traffic_phase())
            1:       idle_pct = 46;
            3:       idle_pct = 37;
            default: idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_card(s, predicted);
        pending_cards = {pending_cards, (typed ? typed_card : predicted)};
        shapes_sent++;
        @(negedge clk);
    endtask

    // Mix ascending runs (grow piles and tails) with noise bursts
    task automatic run_random(input int count);
        int                          done_items;
        int                          run_len;
        int                          k;
        logic [psc_pkg::DIM_W-1:0]   width_dim;
        int                          height_step;
        int                          height_start;
        psc_pkg::shape_in_t          s;
        psc_pkg::card_out_t          none;
        done_items = 0;
        none = '0;
        while (done_items < count)
        begin
            if ($urandom_range(2) == 0)
            begin
                run_len      = $urandom_range(40, 5);
                width_dim    = psc_pkg::DIM_W'($urandom_range(255, 1));
                height_step  = $urandom_range(64, 0);
                height_start = $urandom_range(65535 - run_len * height_step);
                for (k = 0; k < run_len; k++)
                begin
                    s.shape_kind = psc_pkg::SHAPE_RECTANGLE;
                    s.first_dim  = width_dim;
                    s.second_dim = psc_pkg::DIM_W'(height_start + k * height_step);
                    send_shape(s, 1'b0, none);
                end
                done_items += run_len;
            end
            else
            begin
                run_len = $urandom_range(10, 1);
                for (k = 0; k < run_len; k++)
                begin
                    s.shape_kind = psc_pkg::KIND_W'($urandom_range(3));
                    s.first_dim  = pick_dim();
                    s.second_dim = pick_dim();
                    send_shape(s, 1'b0, none);
                end
                done_items += run_len;
            end
        end
    endtask

    // Drive out_ready: random stalls per phase, plus one long hold-off to back up the input
    initial
    begin : drive_ready
        int hold_left;
        bit held;
        int stall_pct;
        hold_left = 0;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && cards_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (traffic_phase())
                    2:       stall_pct = 46;
                    3:       stall_pct = 37;
                    default: stall_pct = 0;
                endcase
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check each card transaction against the oldest expectation
    always @(posedge clk)
    begin : check_card
        psc_pkg::card_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            cards_seen++;
            if (pending_cards.size() == 0)
                note_fault("card transaction with nothing expected");
            else
            begin
                want = pending_cards.pop_front();
                if (out_data.card_area !== want.card_area
                    || out_data.pile_total !== want.pile_total
                    || out_data.tail_total !== want.tail_total
                    || out_data.overflow !== want.overflow)
                    note_fault($sformatf({"area %0d piles %0d tails %0d ovf %0d, ",
                                          "got area %0d piles %0d tails %0d ovf %0d"},
                                         want.card_area, want.pile_total,
                                         want.tail_total, want.overflow,
                                         out_data.card_area, out_data.pile_total,
                                         out_data.tail_total, out_data.overflow));
            end
        end
    end

    initial
    begin : stimulus
        psc_pkg::shape_in_t s;
        psc_pkg::card_out_t none;
        int                 k;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        none     = '0;

        // Directed rows: zero and maximum dimensions, every shape, the unused
        // shape code, floor of odd triangles, equal areas
        directed_rows[0]  = shape_row(psc_pkg::SHAPE_SQUARE, 16'h0000, 16'h0000,
                                      1, 32'd0, 1, 1, 0);
        directed_rows[1]  = shape_row(psc_pkg::SHAPE_SQUARE, 16'h0000, 16'hFFFF,
                                      1, 32'd0, 1, 2, 0);
        directed_rows[2]  = shape_row(psc_pkg::SHAPE_RECTANGLE, 16'hFFFF, 16'hFFFF,
                                      1, MAX_AREA, 2, 3, 0);
        directed_rows[3]  = shape_row(psc_pkg::SHAPE_TRIANGLE, 16'hFFFF, 16'hFFFF,
                                      1, HALF_MAX_AREA, 2, 3, 0);
        directed_rows[4]  = shape_row(SHAPE_UNUSED, 16'hFFFF, 16'h0000,
                                      1, MAX_AREA, 3, 4, 0);
        directed_rows[5]  = shape_row(psc_pkg::SHAPE_TRIANGLE, 16'h0001, 16'h0001,
                                      1, 32'd0, 3, 4, 0);
        directed_rows[6]  = shape_row(psc_pkg::SHAPE_TRIANGLE, 16'h0003, 16'h0001,
                                      1, 32'd1, 3, 4, 0);
        directed_rows[7]  = shape_row(psc_pkg::SHAPE_RECTANGLE, 16'h0000, 16'hFFFF,
                                      1, 32'd0, 3, 4, 0);
        directed_rows[8]  = shape_row(psc_pkg::SHAPE_RECTANGLE, 16'hFFFF, 16'h0000,
                                      1, 32'd0, 3, 4, 0);
        directed_rows[9]  = shape_row(psc_pkg::SHAPE_RECTANGLE, 16'h0001, 16'h0001,
                                      0, 0, 0, 0, 0);
        directed_rows[10] = shape_row(psc_pkg::SHAPE_SQUARE, 16'h0001, 16'hFFFF,
                                      0, 0, 0, 0, 0);
        directed_rows[11] = shape_row(psc_pkg::SHAPE_TRIANGLE, 16'h0002, 16'h0001,
                                      0, 0, 0, 0, 0);
        directed_rows[12] = shape_row(psc_pkg::SHAPE_SQUARE, 16'h8000, 16'h0000,
                                      0, 0, 0, 0, 0);
        directed_rows[13] = shape_row(psc_pkg::SHAPE_RECTANGLE, 16'hAAAA, 16'h5555,
                                      0, 0, 0, 0, 0);
        directed_rows[14] = shape_row(psc_pkg::SHAPE_RECTANGLE, 16'h5555, 16'hAAAA,
                                      0, 0, 0, 0, 0);
        directed_rows[15] = shape_row(psc_pkg::SHAPE_TRIANGLE, 16'hFFFF, 16'h0001,
                                      0, 0, 0, 0, 0);
        directed_rows[16] = shape_row(psc_pkg::SHAPE_SQUARE, 16'hFFFF, 16'h1234,
                                      0, 0, 0, 0, 0);
        directed_rows[17] = shape_row(psc_pkg::SHAPE_SQUARE, 16'hFFFF, 16'h0000,
                                      0, 0, 0, 0, 0);
        directed_rows[18] = shape_row(SHAPE_UNUSED, 16'h0001, 16'hFFFF,
                                      0, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_shape(directed_rows[i].shape, directed_rows[i].typed, directed_rows[i].want);

        run_random(200);

        // Climb toward the top of the area range so both lanes grow long
        for (k = 0; k < RAMP_LEN; k++)
        begin
            s.shape_kind = psc_pkg::SHAPE_RECTANGLE;
            s.first_dim  = 16'hFFFF;
            s.second_dim = psc_pkg::DIM_W'(65535 - (RAMP_LEN - 1) + k);
            send_shape(s, 1'b0, none);
        end

        // Keep going with long lanes: replacements deep in the arrays
        run_random(180);
        in_valid <= 1'b0;

        while (pending_cards.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
